// ===== rtl/tag_nesting_arc_tally_top_defines.svh =====
// Assertion macros for the tag nesting arc tally block.
`ifndef TAG_NESTING_ARC_TALLY_TOP_DEFINES_SVH
`define TAG_NESTING_ARC_TALLY_TOP_DEFINES_SVH
`define TNAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TNAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/tnat_pkg.sv =====
// Package with shared types and constants of the tag nesting arc tally block.
package tnat_pkg;
    localparam logic [2:0] FUNC_PUSH     = 3'd0;
    localparam logic [2:0] FUNC_POP      = 3'd1;
    localparam logic [2:0] FUNC_PUSH_POP = 3'd2;
    localparam logic [2:0] FUNC_DROP     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR    = 3'd4;
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_STACK_FULL = 2'd2;
    localparam logic [4:0] EXP_MAX       = 5'd31;

    typedef struct packed {
        logic        arc_valid;
        logic [7:0]  arc_index;
        logic [7:0]  parent_tag;
        logic [7:0]  child_tag;
        logic [31:0] arc_count;
        logic        sampled;
        logic [3:0]  sample_slots_used;
        logic [6:0]  nest_depth;
        logic        select_flag;
        logic [1:0]  status;
        logic        last;
    } t_result;
endpackage

// ===== rtl/tnat_out_reg.sv =====
// Output register that holds one result transaction until it is taken.
module tnat_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  tnat_pkg::t_result  i_res,
    input  logic               i_stall,
    output logic               o_full,
    output logic               o_valid,
    output tnat_pkg::t_result  o_res
);
    logic              r_valid;
    tnat_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_full  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== rtl/tag_nesting_arc_tally_top.sv =====
// Top level: stack and arc table in synchronous memories, sequenced per arc.
// A push, drop, clear or a pop at the root goes from decode straight to the emit state.
// A pop reads the child and parent from the stack per closed level, searches the arc table
// entry by entry (up to ARC_ENTRIES entries), may do sample work and then emits its result.
// One transaction is in work at a time; the arc table search sets the rate.
// Synchronous active-low reset sets depth 1, no arcs in use and the select flag low.
`include "tag_nesting_arc_tally_top_defines.svh"
module tag_nesting_arc_tally_top #(
    parameter int ARC_ENTRIES  = 256,
    parameter int STACK_LEVELS = 64,
    parameter int SAMPLE_SLOTS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_tag_id,
    input  logic [31:0] i_accepted_base,
    input  logic [19:0] i_match_begin,
    input  logic [19:0] i_match_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_arc_valid,
    output logic [7:0]  o_arc_index,
    output logic [7:0]  o_parent_tag,
    output logic [7:0]  o_child_tag,
    output logic [31:0] o_arc_count,
    output logic        o_sampled,
    output logic [3:0]  o_sample_slots_used,
    output logic [6:0]  o_nest_depth,
    output logic        o_select_flag,
    output logic [1:0]  o_status,
    output logic        o_last
);
    localparam int AW = $clog2(ARC_ENTRIES);
    localparam int SW = $clog2(STACK_LEVELS);
    localparam int DW = $clog2(STACK_LEVELS + 1);
    localparam int NW = $clog2(ARC_ENTRIES + 1);
    localparam int KW = $clog2(SAMPLE_SLOTS + 1);
    localparam int QW = $clog2(ARC_ENTRIES * SAMPLE_SLOTS);
    localparam int LW = $clog2(SAMPLE_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_PAR, S_RD_CHD, S_SEARCH, S_HIT, S_CMP_RD,
        S_CMP_WR, S_EMIT, S_WAIT
    } t_state;

    // Arc entry: parent, child, count, sample count, exponent.
    typedef struct packed {
        logic [7:0]  parent;
        logic [7:0]  child;
        logic [31:0] count;
        logic [KW-1:0] nsamp;
        logic [4:0]  expo;
    } t_arc;

    logic [7:0]  m_stack [STACK_LEVELS];
    t_arc        m_arc   [ARC_ENTRIES];
    logic [52:0] m_samp  [ARC_ENTRIES * SAMPLE_SLOTS];

    t_state      r_state;
    logic [DW-1:0] r_depth;
    logic [NW-1:0] r_used;
    logic        r_sel;
    logic [2:0]  r_func;
    logic [7:0]  r_tag;
    logic [52:0] r_sample;
    logic [7:0]  r_par, r_chd;
    logic [NW-1:0] r_idx;
    logic [SW-1:0] r_srd_addr;
    logic [7:0]  r_srd;
    logic [AW-1:0] r_ard_addr;
    t_arc        r_ard;
    t_arc        r_ent;
    logic [LW-1:0] r_wp;
    logic [QW-1:0] r_qrd_addr;
    logic [52:0] r_qrd;
    logic        r_load;
    tnat_pkg::t_result r_res, n_res;

    logic        out_full;
    tnat_pkg::t_result out_res;

    logic [31:0] count_inc;
    logic [31:0] mask;
    logic [QW-1:0] row;
    logic        full_slots;

    assign o_stall = (r_state != S_IDLE);
    assign count_inc = (r_ard.count == 32'hFFFF_FFFF) ? r_ard.count : r_ard.count + 32'd1;
    assign mask = (32'd1 << r_ard.expo) - 32'd1;
    assign row = QW'(r_idx[AW-1:0] * SAMPLE_SLOTS);
    assign full_slots = (r_ent.nsamp >= KW'(SAMPLE_SLOTS));

    always_ff @(posedge i_clk) begin
        r_srd <= m_stack[r_srd_addr];
        r_ard <= m_arc[r_ard_addr];
        r_qrd <= m_samp[r_qrd_addr];
    end

    always_comb begin
        n_res = '0;
        n_res.nest_depth = 7'(r_depth);
        n_res.select_flag = r_sel;
        n_res.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_load <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= DW'(1);
            r_used  <= '0;
            r_sel   <= 1'b0;
            m_stack[0] <= 8'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func <= i_func;
                        r_tag  <= i_tag_id;
                        r_sample[52:20] <= {1'b0, i_accepted_base} + 33'(i_match_begin);
                        r_sample[19:0] <= (i_match_end > i_match_begin) ?
                                          i_match_end - i_match_begin : 20'd0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_res <= n_res;
                    if (r_func == tnat_pkg::FUNC_PUSH || r_func == tnat_pkg::FUNC_PUSH_POP) begin
                        if (r_depth >= DW'(STACK_LEVELS)) begin
                            r_res.status <= tnat_pkg::ST_STACK_FULL;
                            r_state <= S_EMIT;
                        end else begin
                            m_stack[r_depth[SW-1:0]] <= r_tag;
                            r_depth <= r_depth + DW'(1);
                            if (r_func == tnat_pkg::FUNC_PUSH) begin
                                r_res.nest_depth <= 7'(r_depth + DW'(1));
                                r_state <= S_EMIT;
                            end else begin
                                r_func <= tnat_pkg::FUNC_POP;
                            end
                        end
                    end else if (r_func == tnat_pkg::FUNC_POP) begin
                        if (r_depth > DW'(1)) begin
                            r_srd_addr <= SW'(r_depth - DW'(1));
                            r_state <= S_RD_PAR;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        if (r_func == tnat_pkg::FUNC_DROP && r_depth > DW'(1)) begin
                            r_depth <= r_depth - DW'(1);
                            r_res.nest_depth <= 7'(r_depth - DW'(1));
                        end
                        if (r_func == tnat_pkg::FUNC_CLEAR) begin
                            r_sel <= 1'b0;
                            r_res.select_flag <= 1'b0;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_RD_PAR: begin
                    r_srd_addr <= SW'(r_depth - DW'(2));
                    r_state <= S_RD_CHD;
                end
                S_RD_CHD: begin
                    r_chd <= r_srd;
                    r_idx <= '0;
                    r_ard_addr <= '0;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    // r_srd holds the parent now; entry r_idx is read into r_ard at this edge.
                    r_par <= r_srd;
                    r_srd_addr <= r_srd_addr;
                    r_state <= S_HIT;
                end
                S_HIT: begin
                    if (r_idx == r_used) begin
                        r_res <= n_res;
                        r_res.parent_tag <= r_par;
                        r_res.child_tag <= r_chd;
                        r_res.nest_depth <= 7'(r_depth - DW'(1));
                        r_res.last <= (r_chd == r_tag) || (r_depth == DW'(2));
                        r_depth <= r_depth - DW'(1);
                        if (r_used >= NW'(ARC_ENTRIES)) begin
                            r_res.status <= tnat_pkg::ST_TABLE_FULL;
                            r_state <= S_EMIT;
                        end else begin
                            r_ent <= '{parent: r_par, child: r_chd, count: 32'd1,
                                       nsamp: '0, expo: 5'd0};
                            r_used <= r_used + NW'(1);
                            r_res.arc_valid <= 1'b1;
                            r_res.arc_index <= 8'(r_idx);
                            r_res.arc_count <= 32'd1;
                            r_res.sampled <= 1'b1;
                            r_wp <= '0;
                            r_state <= S_CMP_WR;
                        end
                    end else if (r_ard.parent == r_par && r_ard.child == r_chd) begin
                        r_res <= n_res;
                        r_res.parent_tag <= r_par;
                        r_res.child_tag <= r_chd;
                        r_res.nest_depth <= 7'(r_depth - DW'(1));
                        r_res.last <= (r_chd == r_tag) || (r_depth == DW'(2));
                        r_depth <= r_depth - DW'(1);
                        r_res.arc_valid <= 1'b1;
                        r_res.arc_index <= 8'(r_idx);
                        r_res.arc_count <= count_inc;
                        r_ent <= r_ard;
                        r_ent.count <= count_inc;
                        r_wp <= '0;
                        r_qrd_addr <= row;
                        if ((count_inc & mask) == 32'd0) begin
                            r_res.sampled <= 1'b1;
                            r_state <= S_CMP_WR;
                        end else begin
                            r_res.sample_slots_used <= 4'(r_ard.nsamp);
                            m_arc[r_idx[AW-1:0]] <= '{parent: r_ard.parent,
                                child: r_ard.child, count: count_inc,
                                nsamp: r_ard.nsamp, expo: r_ard.expo};
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_idx <= r_idx + NW'(1);
                        r_ard_addr <= AW'(r_idx + NW'(1));
                        r_state <= S_SEARCH;
                    end
                end
                S_CMP_WR: begin
                    if (!full_slots) begin
                        m_samp[row + QW'(r_ent.nsamp)] <= r_sample;
                        m_arc[r_idx[AW-1:0]] <= '{parent: r_ent.parent, child: r_ent.child,
                            count: r_ent.count, nsamp: r_ent.nsamp + KW'(1),
                            expo: r_ent.expo};
                        r_res.sample_slots_used <= 4'(r_ent.nsamp + KW'(1));
                        r_sel <= 1'b1;
                        r_res.select_flag <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (32'(r_wp) * 2 >= 32'(r_ent.nsamp)) begin
                        m_arc[r_idx[AW-1:0]] <= '{parent: r_ent.parent, child: r_ent.child,
                            count: r_ent.count, nsamp: r_ent.nsamp >> 1,
                            expo: (r_ent.expo < tnat_pkg::EXP_MAX) ?
                                  r_ent.expo + 5'd1 : r_ent.expo};
                        r_res.sample_slots_used <= 4'(r_ent.nsamp >> 1);
                        r_state <= S_EMIT;
                    end else begin
                        r_qrd_addr <= row + QW'({r_wp, 1'b0});
                        r_state <= S_CMP_RD;
                    end
                end
                S_CMP_RD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    m_samp[row + QW'(r_wp)] <= r_qrd;
                    r_wp <= r_wp + LW'(1);
                    r_state <= S_CMP_WR;
                end
                S_EMIT: begin
                    if (!out_full) begin
                        r_load <= 1'b1;
                        if (r_func == tnat_pkg::FUNC_POP && !r_res.last &&
                            r_res.arc_valid | (r_res.status == tnat_pkg::ST_TABLE_FULL)) begin
                            r_srd_addr <= SW'(r_depth - DW'(1));
                            r_state <= S_RD_PAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tnat_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_load),
        .i_res   (r_res),
        .i_stall (i_stall),
        .o_full  (out_full),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_arc_valid         = out_res.arc_valid;
    assign o_arc_index         = out_res.arc_index;
    assign o_parent_tag        = out_res.parent_tag;
    assign o_child_tag         = out_res.child_tag;
    assign o_arc_count         = out_res.arc_count;
    assign o_sampled           = out_res.sampled;
    assign o_sample_slots_used = out_res.sample_slots_used;
    assign o_nest_depth        = out_res.nest_depth;
    assign o_select_flag       = out_res.select_flag;
    assign o_status            = out_res.status;
    assign o_last              = out_res.last;

    `TNAT_ASSERT_IMPL(a_depth_range, i_clk, i_rst_n, 1'b1, r_depth >= DW'(1) && r_depth <= DW'(STACK_LEVELS))
    `TNAT_ASSERT_IMPL(a_used_range, i_clk, i_rst_n, 1'b1, r_used <= NW'(ARC_ENTRIES))
    `TNAT_ASSERT_NEXT(a_load_emit, i_clk, i_rst_n, r_state == S_EMIT && !out_full, r_load)
endmodule
